@@ rtl/ts_sync_marker_detector_macros.svh @@
// Assertion helpers for the checker file tsm_checker.sv.
`ifndef TS_SYNC_MARKER_DETECTOR_MACROS_SVH
`define TS_SYNC_MARKER_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TSM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tsm_pkg.sv @@
`timescale 1ns / 1ps

package tsm_pkg;

    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE  = 1'b1;

    localparam logic [7:0] PACKET_LEN_RESET = 8'd188;
    localparam logic [7:0] SYNC_BYTE_RESET  = 8'h47;
    localparam logic [7:0] MIN_BLOCK        = 8'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] packet_len;
        logic [7:0] sync_byte;
    } cfg_t;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_STEP,
        SC_EVAL,
        SC_DONE
    } scan_state_t;

    typedef enum logic [1:0] {
        MODE_CHECK  = 2'd0,
        MODE_SEARCH = 2'd1,
        MODE_CHAIN  = 2'd2
    } scan_mode_t;

endpackage

@@ rtl/tsm_if.sv @@
`timescale 1ns / 1ps

interface tsm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tsm_out_if #(parameter int COUNT_BITS = 21);
    logic                  valid;
    logic                  ready;
    logic                  detected;
    logic [COUNT_BITS-1:0] hit_count;
    logic [COUNT_BITS-1:0] miss_count;

    modport source (output valid, output detected, output hit_count, output miss_count,
                    input ready);
    modport sink   (input valid, input detected, input hit_count, input miss_count,
                    output ready);
endinterface

interface tsm_cfg_if;
    import tsm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/tsm_queue.sv @@
`timescale 1ns / 1ps

module tsm_queue (
    input  logic           clk,
    input  logic           rst_n,
    tsm_in_if.sink         stream,
    output logic           q_valid,
    output tsm_pkg::item_t q_item,
    input  logic           q_pop
);
    import tsm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;

    assign stream.ready = (count_reg != 2'd2);
    assign push         = stream.valid && stream.ready;
    assign q_valid      = (count_reg != 2'd0);
    assign q_item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{data_byte: stream.data_byte, last_byte: stream.last_byte};
        end
    end

endmodule

@@ rtl/tsm_scan.sv @@
`timescale 1ns / 1ps

module tsm_scan #(
    parameter int RING_DEPTH = 512,
    parameter int COUNT_BITS = 21
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tsm_pkg::cfg_t  cfg_val,
    input  logic           q_valid,
    input  tsm_pkg::item_t q_item,
    output logic           q_pop,
    tsm_out_if.source      result
);
    import tsm_pkg::*;

    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int AVAIL_W = IDX_W + 1;
    localparam int PROD_W  = COUNT_BITS + 3;
    localparam logic [AVAIL_W-1:0]    DEPTH_A   = AVAIL_W'(RING_DEPTH);
    localparam logic [AVAIL_W-1:0]    ONE_A     = AVAIL_W'(1);
    localparam logic [IDX_W-1:0]      IDX_ZERO  = '0;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0]   base,
                                                  input logic [AVAIL_W-1:0] step);
        logic [AVAIL_W-1:0] sum;
        sum = {1'b0, base} + step;
        if (sum >= DEPTH_A)
        begin
            sum = sum - DEPTH_A;
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] val);
        return (val == COUNT_MAX) ? val : val + COUNT_BITS'(1);
    endfunction

    logic [7:0] ring [RING_DEPTH];
    logic [7:0] rd_data_reg;

    scan_state_t           state_reg,    state_next;
    scan_mode_t            mode_reg,     mode_next;
    logic [IDX_W-1:0]      s_reg,        s_next;
    logic [IDX_W-1:0]      w_reg,        w_next;
    logic [COUNT_BITS-1:0] hits_reg,     hits_next;
    logic [COUNT_BITS-1:0] misses_reg,   misses_next;
    logic [AVAIL_W-1:0]    avail_reg,    avail_next;
    logic [7:0]            nb_reg,       nb_next;
    logic                  last_reg,     last_next;
    logic                  use_nb_reg,   use_nb_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_det_reg,  out_det_next;
    logic [COUNT_BITS-1:0] out_hit_reg,  out_hit_next;
    logic [COUNT_BITS-1:0] out_miss_reg, out_miss_next;

    logic [7:0]         block;
    logic [AVAIL_W-1:0] blk_a;
    logic               can_step;
    logic               rd_en;
    logic               rd_far;
    logic               tail;
    logic               stop;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_rd;
    logic               mem_wr;
    logic [AVAIL_W-1:0] stored_cnt;
    logic [7:0]         byte_sel;
    logic               match;
    logic               out_free;
    logic [PROD_W-1:0]  miss_x5;

    assign block      = (cfg_val.packet_len < MIN_BLOCK) ? MIN_BLOCK : cfg_val.packet_len;
    assign blk_a      = {{(AVAIL_W-8){1'b0}}, block};
    assign can_step   = (blk_a < avail_reg);
    assign rd_addr    = rd_far ? wrap_add(s_reg, blk_a) : s_reg;
    assign stored_cnt = (w_reg >= s_reg) ? ({1'b0, w_reg} - {1'b0, s_reg})
                                         : ({1'b0, w_reg} + DEPTH_A - {1'b0, s_reg});
    assign byte_sel   = use_nb_reg ? nb_reg : rd_data_reg;
    assign match      = (byte_sel == cfg_val.sync_byte);
    assign out_free   = !out_valid_reg || result.ready;
    assign miss_x5    = {1'b0, misses_reg, 2'b00} + PROD_W'(misses_reg);

    assign result.valid      = out_valid_reg;
    assign result.detected   = out_det_reg;
    assign result.hit_count  = out_hit_reg;
    assign result.miss_count = out_miss_reg;

    // What the current scan mode needs at this position
    always_comb
    begin
        rd_en  = 1'b0;
        rd_far = 1'b0;
        tail   = 1'b0;
        stop   = 1'b0;
        unique case (mode_reg)
            MODE_SEARCH:
            begin
                if (avail_reg == '0)
                    stop = 1'b1;
                else
                    rd_en = 1'b1;
            end
            MODE_CHAIN:
            begin
                if (can_step)
                begin
                    rd_en  = 1'b1;
                    rd_far = 1'b1;
                end
                else if (last_reg)
                    tail = 1'b1;
                else
                    stop = 1'b1;
            end
            default:
            begin
                if (can_step)
                    rd_en = 1'b1;
                else
                    stop = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (q_valid)
                    state_next = SC_STEP;
            end
            SC_STEP:
            begin
                if (rd_en)
                    state_next = SC_EVAL;
                else if (stop)
                    state_next = SC_DONE;
            end
            SC_EVAL:
            begin
                state_next = SC_STEP;
            end
            SC_DONE:
            begin
                if (!last_reg || out_free)
                    state_next = SC_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mode_next      = mode_reg;
        s_next         = s_reg;
        w_next         = w_reg;
        hits_next      = hits_reg;
        misses_next    = misses_reg;
        avail_next     = avail_reg;
        nb_next        = nb_reg;
        last_next      = last_reg;
        use_nb_next    = use_nb_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_det_next   = out_det_reg;
        out_hit_next   = out_hit_reg;
        out_miss_next  = out_miss_reg;
        q_pop          = 1'b0;
        mem_rd         = 1'b0;
        mem_wr         = 1'b0;
        unique case (state_reg)
            SC_IDLE:
            begin
                q_pop = q_valid;
                if (q_valid)
                begin
                    nb_next    = q_item.data_byte;
                    last_next  = q_item.last_byte;
                    avail_next = stored_cnt + ONE_A;
                end
            end
            SC_STEP:
            begin
                if (rd_en)
                begin
                    mem_rd      = 1'b1;
                    // the newest byte is not in the ring yet
                    use_nb_next = rd_far ? ((blk_a + ONE_A) == avail_reg)
                                         : (avail_reg == ONE_A);
                end
                else if (tail)
                begin
                    s_next     = wrap_add(s_reg, ONE_A);
                    avail_next = avail_reg - ONE_A;
                    mode_next  = MODE_CHECK;
                end
            end
            SC_EVAL:
            begin
                unique case (mode_reg)
                    MODE_SEARCH:
                    begin
                        if (match)
                            mode_next = MODE_CHAIN;
                        else
                        begin
                            s_next     = wrap_add(s_reg, ONE_A);
                            avail_next = avail_reg - ONE_A;
                        end
                    end
                    MODE_CHAIN:
                    begin
                        if (match)
                        begin
                            hits_next  = sat_inc(hits_reg);
                            s_next     = wrap_add(s_reg, blk_a);
                            avail_next = avail_reg - blk_a;
                        end
                        else
                        begin
                            // chain broken: resume one past the last sync byte
                            s_next     = wrap_add(s_reg, ONE_A);
                            avail_next = avail_reg - ONE_A;
                            mode_next  = MODE_CHECK;
                        end
                    end
                    default:
                    begin
                        if (match)
                            mode_next = MODE_CHAIN;
                        else
                        begin
                            misses_next = sat_inc(misses_reg);
                            mode_next   = MODE_SEARCH;
                        end
                    end
                endcase
            end
            SC_DONE:
            begin
                if (last_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_det_next   = (PROD_W'(hits_reg) > miss_x5);
                        out_hit_next   = hits_reg;
                        out_miss_next  = misses_reg;
                        hits_next      = '0;
                        misses_next    = '0;
                        mode_next      = MODE_CHECK;
                        s_next         = IDX_ZERO;
                        w_next         = IDX_ZERO;
                    end
                end
                else
                begin
                    mem_wr = 1'b1;
                    w_next = wrap_add(w_reg, ONE_A);
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SC_IDLE;
            mode_reg      <= MODE_CHECK;
            s_reg         <= '0;
            w_reg         <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            s_reg         <= s_next;
            w_reg         <= w_next;
            hits_reg      <= hits_next;
            misses_reg    <= misses_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nb_reg       <= nb_next;
        last_reg     <= last_next;
        avail_reg    <= avail_next;
        use_nb_reg   <= use_nb_next;
        out_det_reg  <= out_det_next;
        out_hit_reg  <= out_hit_next;
        out_miss_reg <= out_miss_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            ring[w_reg] <= nb_reg;
        end
        if (mem_rd)
        begin
            rd_data_reg <= ring[rd_addr];
        end
    end

endmodule

@@ rtl/ts_sync_marker_detector.sv @@
`timescale 1ns / 1ps
// Order: the scan pops a taken byte when idle, then does a read and a compare per ring read,
// plus a tail step where a chain ends at a last byte, then stores the byte or, for a last byte,
// sends the result; a stall holds it. The scan takes no new byte until it is done with the last
// one; each position is read about once plus one lookahead per chain hop.
// Reset (rst_n low, asynchronous): counts, pointers, scan mode, queue and output valid clear,
// packet_len returns to 188 and sync_byte to 0x47; ring contents are left as they are.

module ts_sync_marker_detector #(
    parameter int RING_DEPTH = 512,
    parameter int COUNT_BITS = 21
) (
    input logic       clk,
    input logic       rst_n,
    tsm_in_if.sink    stream,
    tsm_out_if.source result,
    tsm_cfg_if.sink   cfg
);
    import tsm_pkg::*;

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PACKET_LEN: cfg_next.packet_len = cfg.data;
                CFG_SYNC_BYTE:  cfg_next.sync_byte  = cfg.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{packet_len: PACKET_LEN_RESET, sync_byte: SYNC_BYTE_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tsm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    tsm_scan #(
        .RING_DEPTH (RING_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_val (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

@@ rtl/tsm_checker.sv @@
`timescale 1ns / 1ps
`include "ts_sync_marker_detector_macros.svh"

module tsm_checker #(
    parameter int COUNT_BITS = 21
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  stream_valid,
    input logic                  stream_ready,
    input logic                  stream_last,
    input logic                  result_valid,
    input logic                  result_ready,
    input logic                  result_detected,
    input logic [COUNT_BITS-1:0] result_hit,
    input logic [COUNT_BITS-1:0] result_miss
);
    localparam int PROD_W = COUNT_BITS + 3;

    logic [2:0]        pending_reg;
    logic [2:0]        pending_next;
    logic              last_in;
    logic              res_out;
    logic [PROD_W-1:0] miss_x5;
    logic              det_expect;

    assign last_in    = stream_valid && stream_ready && stream_last;
    assign res_out    = result_valid && result_ready;
    assign miss_x5    = {1'b0, result_miss, 2'b00} + PROD_W'(result_miss);
    assign det_expect = (PROD_W'(result_hit) > miss_x5);

    // count last bytes taken whose result has not gone out yet
    always_comb
    begin
        unique case ({last_in, res_out})
            2'b10:   pending_next = pending_reg + 3'd1;
            2'b01:   pending_next = pending_reg - 3'd1;
            default: pending_next = pending_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `TSM_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_hit) && $stable(result_miss) && $stable(result_detected), "result changed while stalled")
    `TSM_ASSERT_NOW(a_detect_rule, result_valid, result_detected == det_expect, "detected does not match the counts")
    `TSM_ASSERT_NOW(a_result_cause, result_valid, pending_reg != 3'd0, "result without a last byte")

endmodule

bind ts_sync_marker_detector tsm_checker #(
    .COUNT_BITS (COUNT_BITS)
) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .stream_valid    (stream.valid),
    .stream_ready    (stream.ready),
    .stream_last     (stream.last_byte),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_detected (result.detected),
    .result_hit      (result.hit_count),
    .result_miss     (result.miss_count)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tsm_pkg::*;

    localparam int RING          = 512;
    localparam int COUNT_W       = 21;
    localparam int IDLE_PCT      = 24;
    localparam int STALL_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TARGET_BYTES  = 1650;
    localparam int SHOWN_ERRORS  = 10;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic               detected;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] miss_count;
    } probe_report_t;

    typedef enum logic {
        SHAPE_PACKETS,
        SHAPE_NOISE
    } stream_shape_t;

    logic clk;
    logic rst_n;

    tsm_in_if                          stream_if ();
    tsm_out_if #(.COUNT_BITS(COUNT_W)) report_if ();
    tsm_cfg_if                         cfg_if ();

    ts_sync_marker_detector #(
        .RING_DEPTH (RING),
        .COUNT_BITS (COUNT_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .result (report_if),
        .cfg    (cfg_if)
    );

    // Scan predictor state
    logic [7:0]         ring_mem [RING];
    int unsigned        wr_slot;
    int unsigned        scan_slot;
    scan_mode_t         walk_mode;
    logic [COUNT_W-1:0] hit_tally;
    logic [COUNT_W-1:0] miss_tally;
    logic [7:0]         cur_len;
    logic [7:0]         cur_sync;

    probe_report_t pending_reports[$];
    int            mismatches;
    int            bytes_sent;
    int            quiet_cycles;
    bit            steady;
    bit            stall_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_scan();
        wr_slot    = 0;
        scan_slot  = 0;
        walk_mode  = MODE_CHECK;
        hit_tally  = '0;
        miss_tally = '0;
    endfunction

    function automatic int unsigned block_of(input logic [7:0] len);
        return (len < MIN_BLOCK) ? int'(MIN_BLOCK) : int'(len);
    endfunction

    // Walk the buffered bytes as far as the new byte allows; report on the last byte.
    function automatic void predict_probe(input logic [7:0] nb, input logic fin);
        int unsigned   blk;
        int unsigned   stored;
        int unsigned   avail;
        logic [7:0]    b;
        bit            run;
        probe_report_t rep;
        blk    = block_of(cur_len);
        stored = (wr_slot + RING - scan_slot) % RING;
        avail  = stored + 1;
        run    = 1'b1;
        while (run)
        begin
            case (walk_mode)
                MODE_SEARCH:
                begin
                    if (avail == 0)
                        run = 1'b0;
                    else
                    begin
                        b = (stored == 0) ? nb : ring_mem[scan_slot];
                        if (b == cur_sync)
                            walk_mode = MODE_CHAIN;
                        else
                        begin
                            scan_slot = (scan_slot + 1) % RING;
                            if (stored > 0)
                                stored--;
                            avail--;
                        end
                    end
                end
                MODE_CHAIN:
                begin
                    if (blk < avail)
                    begin
                        b = (blk == stored) ? nb : ring_mem[(scan_slot + blk) % RING];
                        if (b == cur_sync)
                        begin
                            if (hit_tally != '1)
                                hit_tally++;
                            scan_slot = (scan_slot + blk) % RING;
                            stored -= blk;
                            avail  -= blk;
                        end
                        else
                        begin
                            scan_slot = (scan_slot + 1) % RING;
                            stored--;
                            avail--;
                            walk_mode = MODE_CHECK;
                        end
                    end
                    else if (fin)
                    begin
                        // buffer ends inside the chain: resume one past the sync byte
                        scan_slot = (scan_slot + 1) % RING;
                        if (stored > 0)
                            stored--;
                        avail--;
                        walk_mode = MODE_CHECK;
                    end
                    else
                        run = 1'b0;
                end
                default:
                begin
                    // check position; the unused mode code behaves the same
                    if (blk < avail)
                    begin
                        b = (stored == 0) ? nb : ring_mem[scan_slot];
                        if (b != cur_sync)
                        begin
                            if (miss_tally != '1)
                                miss_tally++;
                            walk_mode = MODE_SEARCH;
                        end
                        else
                            walk_mode = MODE_CHAIN;
                    end
                    else
                        run = 1'b0;
                end
            endcase
        end

        if (fin)
        begin
            rep.detected   = longint'(hit_tally) > 5 * longint'(miss_tally);
            rep.hit_count  = hit_tally;
            rep.miss_count = miss_tally;
            pending_reports.push_back(rep);
            clear_scan();
        end
        else
        begin
            ring_mem[wr_slot] = nb;
            wr_slot = (wr_slot + 1) % RING;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%s", msg);
    endfunction

    // Keep valid high across back-to-back requests; drop it only on an idle cycle.
    task automatic send_byte(input logic [7:0] value, input logic fin);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        stream_if.valid     <= 1'b1;
        stream_if.data_byte <= value;
        stream_if.last_byte <= fin;
        do
            @(posedge clk);
        while (!stream_if.ready);
        predict_probe(value, fin);
        bytes_sent++;
    endtask

    task automatic send_seq(input byte_q_t seq);
        foreach (seq[i])
            send_byte(seq[i], i == seq.size() - 1);
    endtask

    function automatic byte_q_t build_stream(input stream_shape_t shape,
                                             input int unsigned nbytes);
        byte_q_t     seq;
        int unsigned blk;
        int unsigned lead;
        blk  = block_of(cur_len);
        lead = $urandom_range(0, blk - 1);
        for (int unsigned i = 0; i < nbytes; i++)
        begin
            if (shape == SHAPE_NOISE)
                seq.push_back(($urandom_range(0, 2) == 0) ? cur_sync : 8'($urandom));
            else if (i >= lead && (i - lead) % blk == 0 && $urandom_range(0, 11) != 0)
                seq.push_back(cur_sync);
            else
                seq.push_back(8'($urandom));
        end
        return seq;
    endfunction

    task automatic drain_block();
        stream_if.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] len, input logic [7:0] marker);
        drain_block();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_PACKET_LEN;
        cfg_if.data  <= len;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cur_len = len;
        cfg_if.index <= CFG_SYNC_BYTE;
        cfg_if.data  <= marker;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cur_sync = marker;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_directed();
        // reset settings, then packet lengths 0, 1 and 255 with markers 0x00, 0xFF and 0x80
        send_seq('{8'h47});
        send_seq('{8'h00, 8'hFF});
        set_config(8'd0, 8'h00);
        send_seq('{8'h00, 8'h5A, 8'h00, 8'hA5, 8'h00, 8'hFF, 8'h00});
        set_config(8'd1, 8'hFF);
        send_seq('{8'hFF, 8'h00, 8'hFF, 8'h11, 8'hFF, 8'h22, 8'h33, 8'hFF});
        set_config(8'd255, 8'h80);
        send_seq('{8'h80, 8'h7F, 8'h80, 8'h01});
    endtask

    task automatic test_long_packets();
        set_config(PACKET_LEN_RESET, SYNC_BYTE_RESET);
        steady = 1'b1;
        send_seq(build_stream(SHAPE_PACKETS, 2 * 188 + $urandom_range(1, 60)));
        steady = 1'b0;
        set_config(8'd255, 8'($urandom));
        send_seq(build_stream(SHAPE_PACKETS, 255 + $urandom_range(2, 120)));
    endtask

    task automatic test_backpressure();
        set_config(8'($urandom_range(2, 8)), 8'($urandom));
        stall_request = 1'b1;
        repeat (30)
            send_seq(build_stream(SHAPE_NOISE, $urandom_range(1, 4)));
    endtask

    task automatic test_random_streams();
        int unsigned pick;
        int unsigned len;
        int unsigned blk;
        while (bytes_sent < TARGET_BYTES)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = $urandom_range(0, 1);
            else if (pick == 1)
                len = $urandom_range(17, 64);
            else
                len = $urandom_range(2, 16);
            set_config(8'(len), 8'($urandom));
            blk = block_of(8'(len));
            repeat ($urandom_range(3, 6))
            begin
                if (bytes_sent < TARGET_BYTES)
                    send_seq(build_stream(($urandom_range(0, 3) == 0) ? SHAPE_NOISE
                                                                       : SHAPE_PACKETS,
                                          blk * $urandom_range(1, 5) + $urandom_range(0, blk)));
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        stream_if.valid     = 1'b0;
        stream_if.data_byte = 8'h00;
        stream_if.last_byte = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_PACKET_LEN;
        cfg_if.data         = 8'h00;
        steady              = 1'b0;
        stall_request       = 1'b0;
        cur_len             = PACKET_LEN_RESET;
        cur_sync            = SYNC_BYTE_RESET;
        clear_scan();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_long_packets();
        test_backpressure();
        test_random_streams();
        drain_block();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, one long hold when asked
    initial
    begin
        report_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                report_if.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_request = 1'b0;
            end
            else
                report_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        probe_report_t want;
        if (report_if.valid && report_if.ready)
        begin
            if (pending_reports.size() == 0)
                note_mismatch($sformatf("unexpected result: detected %0d hits %0d misses %0d",
                                        report_if.detected, report_if.hit_count,
                                        report_if.miss_count));
            else
            begin
                want = pending_reports.pop_front();
                if (report_if.detected !== want.detected)
                    note_mismatch($sformatf("detected: expected %0d, got %0d",
                                            want.detected, report_if.detected));
                if (report_if.hit_count !== want.hit_count)
                    note_mismatch($sformatf("hit_count: expected %0d, got %0d",
                                            want.hit_count, report_if.hit_count));
                if (report_if.miss_count !== want.miss_count)
                    note_mismatch($sformatf("miss_count: expected %0d, got %0d",
                                            want.miss_count, report_if.miss_count));
            end
        end
    end

    // Watchdog: end the run when no channel moves a request for too long
    always @(posedge clk)
    begin
        if ((stream_if.valid && stream_if.ready) || (report_if.valid && report_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tsm_pkg.sv
rtl/tsm_if.sv
rtl/tsm_queue.sv
rtl/tsm_scan.sv
rtl/ts_sync_marker_detector.sv
rtl/tsm_checker.sv
verif/tb_top.sv
